// ===== sv/tlbmmu_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbmmu_pkg
// Shared types and constants for the two-level page-walk MMU with TLB.
// ----------------------------------------------------------------------------
package tlbmmu_pkg;

   localparam int unsigned VA_W    = 32;
   localparam int unsigned FRAME_W = 8;
   localparam int unsigned PAGE_W  = 20;
   localparam int unsigned OFF_W   = 12;
   localparam int unsigned IDX_W   = 10;
   localparam int unsigned PTE_W   = 9;
   localparam int unsigned CNT_W   = 9;
   localparam int unsigned PA_W    = 20;
   localparam int unsigned CSR_AW  = 4;
   localparam int unsigned CSR_DW  = 32;

   localparam logic [FRAME_W-1:0] KPOOL_FIRST_RST = 8'd16;
   localparam logic [FRAME_W-1:0] KPOOL_LAST_RST  = 8'd63;
   localparam logic [FRAME_W-1:0] UPOOL_FIRST_RST = 8'd64;
   localparam logic [FRAME_W-1:0] UPOOL_LAST_RST  = 8'd255;

   localparam logic [1:0] CSR_KPOOL_FIRST = 2'd0;
   localparam logic [1:0] CSR_KPOOL_LAST  = 2'd1;
   localparam logic [1:0] CSR_UPOOL_FIRST = 2'd2;
   localparam logic [1:0] CSR_UPOOL_LAST  = 2'd3;

   typedef struct packed {
      logic [VA_W-1:0]    virtual_address;
      logic [FRAME_W-1:0] table_frame;
   } req_type;

   typedef struct packed {
      logic [PA_W-1:0] physical_address;
      logic            tlb_hit;
      logic            pool_fault;
   } rsp_type;

   typedef struct packed {
      logic [FRAME_W-1:0] kpool_first;
      logic [FRAME_W-1:0] kpool_last;
      logic [FRAME_W-1:0] upool_first;
      logic [FRAME_W-1:0] upool_last;
      logic               kpool_reload;
      logic               upool_reload;
   } cfg_type;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic encode;
      logic tlb_read;
      logic rd1;
      logic capture_e1;
      logic rd2;
      logic capture_e2;
      logic wr1;
      logic wr2;
      logic sweep_step;
      logic install;
      logic respond_hit;
      logic respond_fault;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic hit;
      logic t_fault;
      logic u_fault;
      logic ref_at_hand;
   } stat_type;

   typedef enum logic [11:0] {
      ST_CLEAR   = 12'b0000_0000_0001,
      ST_IDLE    = 12'b0000_0000_0010,
      ST_ENC     = 12'b0000_0000_0100,
      ST_DECIDE  = 12'b0000_0000_1000,
      ST_HITRESP = 12'b0000_0001_0000,
      ST_E1      = 12'b0000_0010_0000,
      ST_RD2     = 12'b0000_0100_0000,
      ST_E2      = 12'b0000_1000_0000,
      ST_WR1     = 12'b0001_0000_0000,
      ST_WR2     = 12'b0010_0000_0000,
      ST_SWEEP   = 12'b0100_0000_0000,
      ST_FAULT   = 12'b1000_0000_0000
   } state_type;

endpackage

// ===== sv/tlb_two_level_page_walk_mmu_core.sv =====
// ----------------------------------------------------------------------------
// tlb_two_level_page_walk_mmu_core
// Virtual-to-physical translation with a clock-replaced TLB and a two-level
// page-table walk that allocates missing tables and pages from frame pools.
// ----------------------------------------------------------------------------
// After reset the page-table store is cleared one word per cycle, with busy
// held high until every word is cleared. A transaction is taken when start is
// high and busy is low. A TLB hit is answered on rsp_strobe after the encode,
// decide and hit-response states; a miss goes through the two dependent store
// reads, the two store writes and the one-entry-per-cycle hand sweep past each
// referenced entry. A pool fault is answered once either store read finds that
// its pool is empty. rsp_strobe is high for one cycle and cannot be held off;
// busy drops as the result is presented.
module tlb_two_level_page_walk_mmu_core #(
   parameter int unsigned TLB_ENTRIES = 64,
   parameter int unsigned FRAME_COUNT = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  tlbmmu_pkg::req_type                  req_payload,
   output logic                                 rsp_strobe,
   output tlbmmu_pkg::rsp_type                  rsp_payload,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [tlbmmu_pkg::CSR_AW-1:0]        paddr,
   input  logic [tlbmmu_pkg::CSR_DW-1:0]        pwdata,
   output logic [tlbmmu_pkg::CSR_DW-1:0]        prdata,
   output logic                                 pready
);
   import tlbmmu_pkg::*;

   logic [FRAME_W-1:0] kpf_ff, kpl_ff, upf_ff, upl_ff;
   logic               csr_wr;
   logic [1:0]         csr_idx;
   cfg_type            cfg;
   cmd_type            cmd;
   stat_type           stat;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         kpf_ff <= KPOOL_FIRST_RST;
         kpl_ff <= KPOOL_LAST_RST;
         upf_ff <= UPOOL_FIRST_RST;
         upl_ff <= UPOOL_LAST_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_KPOOL_FIRST: kpf_ff <= pwdata[FRAME_W-1:0];
            CSR_KPOOL_LAST:  kpl_ff <= pwdata[FRAME_W-1:0];
            CSR_UPOOL_FIRST: upf_ff <= pwdata[FRAME_W-1:0];
            CSR_UPOOL_LAST:  upl_ff <= pwdata[FRAME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_KPOOL_FIRST: prdata = {{(CSR_DW-FRAME_W){1'b0}}, kpf_ff};
         CSR_KPOOL_LAST:  prdata = {{(CSR_DW-FRAME_W){1'b0}}, kpl_ff};
         CSR_UPOOL_FIRST: prdata = {{(CSR_DW-FRAME_W){1'b0}}, upf_ff};
         CSR_UPOOL_LAST:  prdata = {{(CSR_DW-FRAME_W){1'b0}}, upl_ff};
         default:         prdata = '0;
      endcase
   end

   always_comb begin
      cfg.kpool_first  = csr_wr ? pwdata[FRAME_W-1:0] : kpf_ff;
      cfg.kpool_last   = kpl_ff;
      cfg.upool_first  = csr_wr ? pwdata[FRAME_W-1:0] : upf_ff;
      cfg.upool_last   = upl_ff;
      cfg.kpool_reload = csr_wr && (csr_idx == CSR_KPOOL_FIRST);
      cfg.upool_reload = csr_wr && (csr_idx == CSR_UPOOL_FIRST);
   end

   tlbmmu_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   tlbmmu_dpath #(
      .TLB_ENTRIES (TLB_ENTRIES),
      .FRAME_COUNT (FRAME_COUNT)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .cfg         (cfg),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== sv/tlbmmu_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlbmmu_ctrl
// Sequencer for lookup, table walk, clock sweep and store clearing.
// ----------------------------------------------------------------------------
module tlbmmu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tlbmmu_pkg::stat_type stat,
   output tlbmmu_pkg::cmd_type  cmd
);
   import tlbmmu_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_ENC;
            end
         end
         ST_ENC: begin
            cmd.encode = 1'b1;
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (stat.hit) begin
               cmd.tlb_read = 1'b1;
               state_in     = ST_HITRESP;
            end else begin
               cmd.rd1  = 1'b1;
               state_in = ST_E1;
            end
         end
         ST_HITRESP: begin
            cmd.respond_hit = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_E1: begin
            if (stat.t_fault) begin
               state_in = ST_FAULT;
            end else begin
               cmd.capture_e1 = 1'b1;
               state_in       = ST_RD2;
            end
         end
         ST_RD2: begin
            cmd.rd2  = 1'b1;
            state_in = ST_E2;
         end
         ST_E2: begin
            if (stat.u_fault) begin
               state_in = ST_FAULT;
            end else begin
               cmd.capture_e2 = 1'b1;
               state_in       = ST_WR1;
            end
         end
         ST_WR1: begin
            cmd.wr1  = 1'b1;
            state_in = ST_WR2;
         end
         ST_WR2: begin
            cmd.wr2  = 1'b1;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (stat.ref_at_hand) begin
               cmd.sweep_step = 1'b1;
            end else begin
               cmd.install = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_FAULT: begin
            cmd.respond_fault = 1'b1;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== sv/tlbmmu_dpath.sv =====
// ----------------------------------------------------------------------------
// tlbmmu_dpath
// TLB cells, page-table store, frame pools and result register.
// ----------------------------------------------------------------------------
module tlbmmu_dpath #(
   parameter int unsigned TLB_ENTRIES = 64,
   parameter int unsigned FRAME_COUNT = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tlbmmu_pkg::cmd_type  cmd,
   output tlbmmu_pkg::stat_type stat,
   input  tlbmmu_pkg::cfg_type  cfg,
   input  tlbmmu_pkg::req_type  req_payload,
   output logic                 rsp_strobe,
   output tlbmmu_pkg::rsp_type  rsp_payload
);
   import tlbmmu_pkg::*;

   localparam int unsigned HW          = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam int unsigned FW          = $clog2(FRAME_COUNT);
   localparam int unsigned AW          = FW + OFF_W;
   localparam int unsigned STORE_DEPTH = FRAME_COUNT * (1 << OFF_W);
   localparam int unsigned FRAME_SPAN  = 1 << FRAME_W;

   // frame number reduced modulo the frame count
   logic [FW-1:0] frame_mod [FRAME_SPAN];
   for (genvar g = 0; g < FRAME_SPAN; g++) begin : g_mod
      assign frame_mod[g] = FW'(g % FRAME_COUNT);
   end

   // request
   logic [VA_W-1:0]    va_ff;
   logic [FRAME_W-1:0] tf_ff;

   // TLB
   logic                 valid_ff [TLB_ENTRIES];
   logic                 ref_ff   [TLB_ENTRIES];
   logic [FRAME_W-1:0]   etf_ff   [TLB_ENTRIES];
   logic [PAGE_W-1:0]    epage_ff [TLB_ENTRIES];
   logic [FRAME_W-1:0]   eframe_mem [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0] match_ff;
   logic [HW-1:0]        hit_idx_ff, hit_idx_in;
   logic                 hit_ff, hit_in;
   logic [FRAME_W-1:0]   hit_frame_ff;
   logic [HW-1:0]        hand_ff, hand_next;

   // page-table store
   logic [PTE_W-1:0] store_mem [STORE_DEPTH];
   logic [PTE_W-1:0] rdata_ff;
   logic [AW-1:0]    clr_ff;
   logic [AW-1:0]    i1, i2, raddr, waddr;
   logic [PTE_W-1:0] wdata;
   logic             wen, ren;
   logic [PTE_W-1:0] e1_ff, e2_ff, e2_raw;
   logic             need_t_ff, need_u_ff, need_t_in, need_u_in;
   logic [CNT_W-1:0] ntf_ff, nuf_ff;

   // response
   logic    rsp_strobe_ff;
   rsp_type rsp_ff;

   assign i1 = {frame_mod[tf_ff], 2'b00, va_ff[VA_W-1 -: IDX_W]};
   assign i2 = {frame_mod[e1_ff[FRAME_W-1:0]], 2'b00, va_ff[OFF_W +: IDX_W]};

   assign need_t_in = ~rdata_ff[PTE_W-1];
   assign e2_raw    = (need_t_ff && (i2 == i1)) ? e1_ff : rdata_ff;
   assign need_u_in = ~e2_raw[PTE_W-1];

   assign hand_next = (hand_ff == HW'(TLB_ENTRIES - 1)) ? '0 : hand_ff + 1'b1;

   always_comb begin
      hit_in     = 1'b0;
      hit_idx_in = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_in     = 1'b1;
            hit_idx_in = HW'(i);
         end
      end
   end

   always_comb begin
      stat.clear_done  = (clr_ff == AW'(STORE_DEPTH - 1));
      stat.hit         = hit_ff;
      stat.t_fault     = need_t_in && (ntf_ff > {1'b0, cfg.kpool_last});
      stat.u_fault     = need_u_in && (nuf_ff > {1'b0, cfg.upool_last});
      stat.ref_at_hand = ref_ff[hand_ff];
   end

   always_comb begin
      ren   = cmd.rd1 | cmd.rd2;
      raddr = cmd.rd2 ? i2 : i1;
      wen   = 1'b0;
      waddr = clr_ff;
      wdata = '0;
      if (cmd.clear_step) begin
         wen = 1'b1;
      end else if (cmd.wr1) begin
         wen   = need_t_ff;
         waddr = i1;
         wdata = e1_ff;
      end else if (cmd.wr2) begin
         wen   = need_u_ff;
         waddr = i2;
         wdata = e2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ren) rdata_ff <= store_mem[raddr];
      if (wen) store_mem[waddr] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.tlb_read) hit_frame_ff <= eframe_mem[hit_idx_ff];
      if (cmd.install)  eframe_mem[hand_ff] <= e2_ff[FRAME_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         va_ff <= req_payload.virtual_address;
         tf_ff <= req_payload.table_frame;
         for (int i = 0; i < TLB_ENTRIES; i++) begin
            match_ff[i] <= valid_ff[i] && (etf_ff[i] == req_payload.table_frame)
                        && (epage_ff[i] == req_payload.virtual_address[VA_W-1:OFF_W]);
         end
      end
      if (cmd.encode) begin
         hit_idx_ff <= hit_idx_in;
      end
      if (cmd.capture_e1) begin
         e1_ff <= need_t_in ? {1'b1, ntf_ff[FRAME_W-1:0]} : rdata_ff;
      end
      if (cmd.capture_e2) begin
         e2_ff <= need_u_in ? {1'b1, nuf_ff[FRAME_W-1:0]} : e2_raw;
      end
      if (cmd.install) begin
         etf_ff[hand_ff]   <= tf_ff;
         epage_ff[hand_ff] <= va_ff[VA_W-1:OFF_W];
      end
      if (cmd.respond_hit) begin
         rsp_ff.physical_address <= {hit_frame_ff, va_ff[OFF_W-1:0]};
         rsp_ff.tlb_hit          <= 1'b1;
         rsp_ff.pool_fault       <= 1'b0;
      end else if (cmd.install) begin
         rsp_ff.physical_address <= {e2_ff[FRAME_W-1:0], va_ff[OFF_W-1:0]};
         rsp_ff.tlb_hit          <= 1'b0;
         rsp_ff.pool_fault       <= 1'b0;
      end else if (cmd.respond_fault) begin
         rsp_ff.physical_address <= '0;
         rsp_ff.tlb_hit          <= 1'b0;
         rsp_ff.pool_fault       <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TLB_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            ref_ff[i]   <= 1'b0;
         end
         hit_ff        <= 1'b0;
         hand_ff       <= '0;
         clr_ff        <= '0;
         need_t_ff     <= 1'b0;
         need_u_ff     <= 1'b0;
         ntf_ff        <= {1'b0, KPOOL_FIRST_RST};
         nuf_ff        <= {1'b0, UPOOL_FIRST_RST};
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.respond_hit | cmd.install | cmd.respond_fault;
         if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
         if (cmd.encode) hit_ff <= hit_in;
         if (cmd.tlb_read) ref_ff[hit_idx_ff] <= 1'b1;
         if (cmd.capture_e1) need_t_ff <= need_t_in;
         if (cmd.capture_e2) need_u_ff <= need_u_in;
         if (cmd.wr1 && need_t_ff) ntf_ff <= ntf_ff + 1'b1;
         if (cmd.wr2 && need_u_ff) nuf_ff <= nuf_ff + 1'b1;
         if (cfg.kpool_reload) ntf_ff <= {1'b0, cfg.kpool_first};
         if (cfg.upool_reload) nuf_ff <= {1'b0, cfg.upool_first};
         if (cmd.sweep_step) begin
            ref_ff[hand_ff] <= 1'b0;
            hand_ff         <= hand_next;
         end
         if (cmd.install) begin
            valid_ff[hand_ff] <= 1'b1;
            ref_ff[hand_ff]   <= 1'b0;
            hand_ff           <= hand_next;
         end
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== dv/tlb_two_level_page_walk_mmu_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tlb_two_level_page_walk_mmu_core_tb
// Self-checking testbench. Drives translation transactions with random gaps
// and mirrors the TLB, the clock hand, the frame pools and the page-table
// store so that each result can be predicted and compared field by field.
// ----------------------------------------------------------------------------
module tlb_two_level_page_walk_mmu_core_tb;
   import tlbmmu_pkg::*;

   localparam int unsigned ENTRIES   = 64;
   localparam int unsigned STORE_WDS = 256 * 4096;
   localparam int unsigned WD_LIMIT  = 3000000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   req_type             req_payload = '0;
   logic                rsp_strobe;
   rsp_type             rsp_payload;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [CSR_AW-1:0]   paddr = '0;
   logic [CSR_DW-1:0]   pwdata = '0;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   tlb_two_level_page_walk_mmu_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // translation model state
   logic [7:0]  kp_first, kp_last, up_first, up_last;
   logic        tlb_valid [ENTRIES];
   logic        tlb_ref   [ENTRIES];
   logic [7:0]  tlb_tf    [ENTRIES];
   logic [19:0] tlb_page  [ENTRIES];
   logic [7:0]  tlb_frame [ENTRIES];
   logic [5:0]  hand;
   int unsigned next_kframe, next_uframe;
   logic [8:0]  pte_store [int unsigned];

   rsp_type     pending_xlat [$];
   int          errors = 0;
   int          n_sent = 0, n_hits = 0, n_faults = 0, n_checked = 0;
   int          idle_cycles = 0;
   bit          gaps_on = 1'b1;
   logic        csr_acc;

   function automatic logic [8:0] pte_rd(int unsigned idx);
      return pte_store.exists(idx) ? pte_store[idx] : 9'd0;
   endfunction

   function automatic rsp_type translate(logic [31:0] va, logic [7:0] tf);
      rsp_type     r;
      int unsigned i1, i2;
      logic [8:0]  e1, e2;
      bit          need_t, need_u;
      r = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (tlb_valid[i] && tlb_tf[i] == tf && tlb_page[i] == va[31:12]) begin
            tlb_ref[i] = 1'b1;
            r.physical_address = {tlb_frame[i], va[11:0]};
            r.tlb_hit = 1'b1;
            return r;
         end
      end
      i1 = (tf * 4096 + va[31:22]) % STORE_WDS;
      e1 = pte_rd(i1);
      need_t = !e1[8];
      if (need_t) begin
         if (next_kframe > kp_last) begin
            r.pool_fault = 1'b1;
            return r;
         end
         e1 = {1'b1, next_kframe[7:0]};
      end
      i2 = (e1[7:0] * 4096 + va[21:12]) % STORE_WDS;
      e2 = (need_t && i2 == i1) ? e1 : pte_rd(i2);
      need_u = !e2[8];
      if (need_u) begin
         if (next_uframe > up_last) begin
            r.pool_fault = 1'b1;
            return r;
         end
         e2 = {1'b1, next_uframe[7:0]};
      end
      if (need_t) begin
         pte_store[i1] = e1;
         next_kframe++;
      end
      if (need_u) begin
         pte_store[i2] = e2;
         next_uframe++;
      end
      while (tlb_ref[hand]) begin
         tlb_ref[hand] = 1'b0;
         hand++;
      end
      tlb_valid[hand] = 1'b1;
      tlb_ref[hand]   = 1'b0;
      tlb_tf[hand]    = tf;
      tlb_page[hand]  = va[31:12];
      tlb_frame[hand] = e2[7:0];
      hand++;
      r.physical_address = {e2[7:0], va[11:0]};
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_v);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, exp_v, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_xlat.size() == 0) begin
            report_mismatch("unexpected transaction", 32'(rsp_payload), 32'd0);
         end else begin
            rsp_type e;
            e = pending_xlat.pop_front();
            n_checked++;
            if (rsp_payload.physical_address !== e.physical_address)
               report_mismatch("physical_address", 32'(rsp_payload.physical_address),
                               32'(e.physical_address));
            if (rsp_payload.tlb_hit !== e.tlb_hit)
               report_mismatch("tlb_hit", 32'(rsp_payload.tlb_hit), 32'(e.tlb_hit));
            if (rsp_payload.pool_fault !== e.pool_fault)
               report_mismatch("pool_fault", 32'(rsp_payload.pool_fault),
                               32'(e.pool_fault));
         end
      end
   end

   assign csr_acc = psel && penable && pwrite && pready;

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || csr_acc) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
         $display("watchdog expired with %0d transactions outstanding", pending_xlat.size());
         $display("tlb_two_level_page_walk_mmu_core regression: fail");
         $finish;
      end
   end

   task automatic wait_cycles(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic maybe_gap();
      if (gaps_on && $urandom_range(0, 3) == 0) wait_cycles($urandom_range(1, 13));
   endtask

   task automatic send_xlat(logic [31:0] va, logic [7:0] tf);
      start <= 1'b1;
      req_payload <= '{virtual_address: va, table_frame: tf};
      do @(posedge clock); while (busy);
      pending_xlat.push_back(translate(va, tf));
      n_sent++;
      if (pending_xlat[$].tlb_hit) n_hits++;
      if (pending_xlat[$].pool_fault) n_faults++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_xlat.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [7:0] val);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= CSR_AW'({idx, 2'b00}); pwdata <= {8'($urandom_range(0, 255)), 16'h0, val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         CSR_KPOOL_FIRST: begin kp_first = val; next_kframe = val; end
         CSR_KPOOL_LAST:  kp_last = val;
         CSR_UPOOL_FIRST: begin up_first = val; next_uframe = val; end
         CSR_UPOOL_LAST:  up_last = val;
         default: begin
         end
      endcase
   endtask

   task automatic set_pools(logic [7:0] kf, logic [7:0] kl, logic [7:0] uf, logic [7:0] ul);
      drain();
      csr_write(CSR_KPOOL_FIRST, kf);
      csr_write(CSR_KPOOL_LAST, kl);
      csr_write(CSR_UPOOL_FIRST, uf);
      csr_write(CSR_UPOOL_LAST, ul);
   endtask

   task automatic test_directed();
      send_xlat(32'h0000_0000, 8'd0);
      send_xlat(32'h0000_0FFF, 8'd0);
      send_xlat(32'hFFFF_FFFF, 8'd255);
      send_xlat(32'hFFFF_F000, 8'd255);
      send_xlat(32'hFFC0_0000, 8'd0);
      send_xlat(32'h003F_F123, 8'd0);
      send_xlat(32'h003F_F456, 8'd0);
      send_xlat(32'hAAAA_AAAA, 8'hAA);
      send_xlat(32'h5555_5555, 8'h55);
      // second-level table placed in the same frame as the first-level table
      set_pools(8'd5, 8'd6, 8'd0, 8'd255);
      send_xlat({10'd3, 10'd3, 12'h321}, 8'd5);
      send_xlat({10'd3, 10'd3, 12'h000}, 8'd5);
      send_xlat({10'd7, 10'd9, 12'h0AB}, 8'd5);
      // kernel pool runs dry
      send_xlat({10'd8, 10'd1, 12'h0}, 8'd5);
      send_xlat({10'd9, 10'd1, 12'h0}, 8'd5);
      // first above last: both pools empty from the start
      set_pools(8'd200, 8'd100, 8'd255, 8'd0);
      send_xlat(32'h1234_5678, 8'd9);
      send_xlat({10'd3, 10'd3, 12'hFFF}, 8'd5);
      // user pool exhausted while kernel pool has room
      set_pools(8'd0, 8'd255, 8'd255, 8'd255);
      send_xlat(32'h0100_0000, 8'd1);
      send_xlat(32'h0100_1000, 8'd1);
      send_xlat(32'h0100_0000, 8'd1);
   endtask

   task automatic test_random(int count);
      logic [31:0] va;
      logic [7:0]  tf;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0: begin va = $urandom; tf = 8'($urandom); end
            1, 2: begin va = $urandom; tf = 8'($urandom_range(0, 3)); end
            default: begin
               va[31:22] = 10'($urandom_range(0, 3));
               va[21:12] = 10'($urandom_range(0, 39));
               va[11:0]  = 12'($urandom);
               tf = 8'($urandom_range(0, 3));
            end
         endcase
         send_xlat(va, tf);
         if (n == count / 2) begin
            start <= 1'b0;
            while (pending_xlat.size() != 0) @(posedge clock);
         end
         maybe_gap();
      end
   endtask

   initial begin
      kp_first = KPOOL_FIRST_RST; kp_last = KPOOL_LAST_RST;
      up_first = UPOOL_FIRST_RST; up_last = UPOOL_LAST_RST;
      next_kframe = kp_first; next_uframe = up_first;
      hand = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         tlb_valid[i] = 1'b0; tlb_ref[i] = 1'b0;
         tlb_tf[i] = '0; tlb_page[i] = '0; tlb_frame[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      set_pools(KPOOL_FIRST_RST, KPOOL_LAST_RST, UPOOL_FIRST_RST, UPOOL_LAST_RST);
      test_random(600);
      set_pools(8'd0, 8'd255, 8'd0, 8'd255);
      test_random(600);
      set_pools(8'd120, 8'd123, 8'd250, 8'd255);
      test_random(400);
      gaps_on = 1'b0;
      set_pools(8'd30, 8'd90, 8'd100, 8'd200);
      test_random(400);
      drain();
      $display("covered %0d translations: %0d TLB hits, %0d pool faults, %0d checked",
               n_sent, n_hits, n_faults, n_checked);
      $display("pool settings included full range, empty, single-frame and reset values");
      if (errors == 0) begin
         $display("tlb_two_level_page_walk_mmu_core regression: pass");
      end else begin
         $display("tlb_two_level_page_walk_mmu_core regression: fail");
      end
      $finish;
   end

endmodule
